// ===== sv/base58_encoder_assert.svh =====
// Assertion macros shared by the base58 encoder checker.
// Depends on: signals named clock and reset in the scope that uses them.
`ifndef BASE58_ENCODER_ASSERT_SVH
`define BASE58_ENCODER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define B58E_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define B58E_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/b58e_pkg.sv =====
// Shared types, constants and functions of the base58 encoder.
// Depends on: nothing.
`default_nettype none

package b58e_pkg;

   localparam int NUM_BYTES_DEF   = 25;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int OUT_DEPTH_DEF   = 2;

   // Leading-zero count width; covers zero counts of up to 127 bytes
   localparam int LZ_W = 7;

   localparam logic [6:0] BASE58   = 7'd58;
   localparam logic [7:0] CHAR_ONE = 8'h31;

   localparam logic [8*58-1:0] ALPHABET =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   // One classified input byte, front to back
   typedef struct packed {
      logic [7:0]      data_byte;
      logic            last;
      logic            mode;
      logic            nonzero;
      logic [LZ_W-1:0] lz;
   } byte_entry_type;

   // One output character
   typedef struct packed {
      logic [7:0] symbol;
      logic       last_symbol;
      logic       empty_result;
   } sym_entry_type;

   typedef struct packed {
      logic [7:0] quot;
      logic [5:0] rem;
   } div_step_type;

   // Divide (rem * 256 + din) by 58, one quotient bit per restoring step
   function automatic div_step_type div_step(input logic [5:0] rem, input logic [7:0] din);
      logic [6:0]   r;
      logic [7:0]   q;
      div_step_type res;
      r = {1'b0, rem};
      q = '0;
      for (int i = 7; i >= 0; i--) begin
         r = {r[5:0], din[i]};
         if (r >= BASE58) begin
            r    = r - BASE58;
            q[i] = 1'b1;
         end
      end
      res.quot = q;
      res.rem  = r[5:0];
      return res;
   endfunction

   // Map a digit to its character; out-of-range digits map to the zero digit
   function automatic logic [7:0] alpha_char(input logic [5:0] d);
      logic [5:0] k;
      k = (d < 6'd58) ? d : 6'd0;
      return ALPHABET[8*(57 - int'(k)) +: 8];
   endfunction

endpackage

`default_nettype wire

// ===== sv/base58_encoder.sv =====
// Top level of the base58 encoder: front end, byte queue, back end, result queue.
// Depends on: b58e_pkg, b58e_front, b58e_queue, b58e_back.
//
//   Channel   Handshake            Payload
//   input     push / full          req_data_byte
//   result    pop / empty          rsp_symbol, rsp_last_symbol, rsp_empty_result
//   config    valid / ready        csr_leading_ones_mode
//
// The front end takes one byte per cycle into a QUEUE_DEPTH entry byte queue while
// that queue is not full. Per number the back end first loads its work memory, then
// runs one byte-serial divide by 58 per base58 digit (one memory read and write-back
// per cycle), then emits the leading '1' characters and the digit characters, each
// digit read from the stack before it is sent.
// Reset is synchronous and clears all control state; the memories need no clear.
// Either side may stall freely; the queues hold bytes and characters meanwhile.
`default_nettype none

module base58_encoder
   import b58e_pkg::*;
#(
   parameter int NUM_BYTES   = NUM_BYTES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // input channel
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_data_byte,
   // result channel
   input  wire logic       pop,
   output logic            empty,
   output logic [7:0]      rsp_symbol,
   output logic            rsp_last_symbol,
   output logic            rsp_empty_result,
   // configuration channel
   input  wire logic       valid,
   output logic            ready,
   input  wire logic       csr_leading_ones_mode
);

   logic           mode_ff, mode_in;
   logic           fq_push, fq_full, fq_empty, fq_pop;
   byte_entry_type fq_wdata, fq_rdata;
   logic           oq_push, oq_full;
   sym_entry_type  oq_wdata, oq_rdata;

   // The configuration channel is always ready, so a write always completes
   assign ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (valid && ready) begin
         mode_in = csr_leading_ones_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Classify each byte, mark the last byte of a number and tag bytes with mode and zero count
   b58e_front #(
      .NUM_BYTES(NUM_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .data_byte (req_data_byte),
      .full      (full),
      .mode      (mode_ff),
      .q_push    (fq_push),
      .q_entry   (fq_wdata),
      .q_full    (fq_full)
   );

   // Decouple byte intake from the long divide loop
   b58e_queue #(
      .WIDTH($bits(byte_entry_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_byte_q (
      .clock (clock),
      .reset (reset),
      .push  (fq_push),
      .wdata (fq_wdata),
      .full  (fq_full),
      .pop   (fq_pop),
      .rdata (fq_rdata),
      .empty (fq_empty)
   );

   // Divide by 58 and emit characters most significant first
   b58e_back #(
      .NUM_BYTES(NUM_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_empty  (fq_empty),
      .in_entry  (fq_rdata),
      .in_pop    (fq_pop),
      .out_full  (oq_full),
      .out_push  (oq_push),
      .out_entry (oq_wdata)
   );

   // Hold finished characters until the consumer takes them
   b58e_queue #(
      .WIDTH($bits(sym_entry_type)),
      .DEPTH(OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (oq_push),
      .wdata (oq_wdata),
      .full  (oq_full),
      .pop   (pop),
      .rdata (oq_rdata),
      .empty (empty)
   );

   assign rsp_symbol       = oq_rdata.symbol;
   assign rsp_last_symbol  = oq_rdata.last_symbol;
   assign rsp_empty_result = oq_rdata.empty_result;

endmodule

`default_nettype wire

// ===== sv/b58e_queue.sv =====
// Small synchronous queue of packed entries.
// Depends on: nothing.
`default_nettype none

module b58e_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = mem_ff[rptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ===== sv/b58e_front.sv =====
// Front end: accepts input bytes, tracks position and leading zeros.
// Depends on: b58e_pkg.
`default_nettype none

module b58e_front
   import b58e_pkg::*;
#(
   parameter int NUM_BYTES = NUM_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic [7:0] data_byte,
   output logic            full,
   input  wire logic       mode,
   output logic            q_push,
   output byte_entry_type  q_entry,
   input  wire logic       q_full
);

   localparam int IDX_W = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;

   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [LZ_W-1:0]  lz_ff, lz_in;
   logic             lead_ff, lead_in;
   logic             zero_lead;
   logic             is_last;

   assign full      = q_full;
   assign q_push    = push & ~q_full;
   assign zero_lead = lead_ff && (data_byte == 8'd0);
   assign is_last   = (cnt_ff == IDX_W'(NUM_BYTES - 1));

   always_comb begin
      q_entry.data_byte = data_byte;
      q_entry.last      = is_last;
      q_entry.mode      = mode;
      q_entry.nonzero   = ~zero_lead;
      q_entry.lz        = lz_ff + LZ_W'(zero_lead);

      cnt_in  = cnt_ff;
      lz_in   = lz_ff;
      lead_in = lead_ff;
      if (q_push) begin
         if (is_last) begin
            // restart for the next number
            cnt_in  = '0;
            lz_in   = '0;
            lead_in = 1'b1;
         end else begin
            cnt_in  = cnt_ff + 1'b1;
            lz_in   = q_entry.lz;
            lead_in = zero_lead;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         lz_ff   <= '0;
         lead_ff <= 1'b1;
      end else begin
         cnt_ff  <= cnt_in;
         lz_ff   <= lz_in;
         lead_ff <= lead_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/b58e_back.sv =====
// Back end: holds the number, divides it by 58 byte-serially, emits characters.
// Depends on: b58e_pkg.
`default_nettype none

module b58e_back
   import b58e_pkg::*;
#(
   parameter int NUM_BYTES = NUM_BYTES_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_empty,
   input  wire byte_entry_type  in_entry,
   output logic                 in_pop,
   input  wire logic            out_full,
   output logic                 out_push,
   output sym_entry_type        out_entry
);

   localparam int IDX_W      = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
   localparam int CNT_W      = $clog2(NUM_BYTES + 1);
   localparam int MAX_DIGITS = (NUM_BYTES * 800) / 585 + 2;
   localparam int SAW        = $clog2(MAX_DIGITS);
   localparam int DCW        = $clog2(MAX_DIGITS + 1);

   typedef enum logic [5:0] {
      S_LOAD  = 6'b000001,
      S_DIV   = 6'b000010,
      S_ONES  = 6'b000100,
      S_RD    = 6'b001000,
      S_DIGIT = 6'b010000,
      S_EMPTY = 6'b100000
   } back_state_type;

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] load_idx_ff, load_idx_in;
   logic [CNT_W-1:0] div_idx_ff, div_idx_in;
   logic [5:0]       rem_ff, rem_in;
   logic             nz_ff, nz_in;
   logic [DCW-1:0]   dig_cnt_ff, dig_cnt_in;
   logic [LZ_W-1:0]  ones_left_ff, ones_left_in;

   // number work memory
   logic [7:0]       work_mem [NUM_BYTES];
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [7:0]       wr_data;
   logic [7:0]       rd_data_ff;
   logic [CNT_W-1:0] wb_idx;

   // digit stack memory
   logic [5:0]       stack_mem [MAX_DIGITS];
   logic             stk_we, stk_rd_en;
   logic [DCW-1:0]   stk_rd_idx;
   logic [5:0]       stk_rd_ff;

   div_step_type     divres;
   logic             nz_step;
   logic [DCW-1:0]   dig_next;

   assign rd_addr    = (div_idx_ff < CNT_W'(NUM_BYTES)) ? div_idx_ff[IDX_W-1:0] : '0;
   assign wb_idx     = div_idx_ff - 1'b1;
   assign stk_rd_idx = dig_cnt_ff - 1'b1;
   assign divres     = div_step(rem_ff, rd_data_ff);
   assign nz_step    = nz_ff | (divres.quot != 8'd0);
   assign dig_next   = dig_cnt_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      load_idx_in  = load_idx_ff;
      div_idx_in   = div_idx_ff;
      rem_in       = rem_ff;
      nz_in        = nz_ff;
      dig_cnt_in   = dig_cnt_ff;
      ones_left_in = ones_left_ff;
      wr_en        = 1'b0;
      wr_addr      = load_idx_ff;
      wr_data      = in_entry.data_byte;
      stk_we       = 1'b0;
      stk_rd_en    = 1'b0;
      in_pop       = 1'b0;
      out_push     = 1'b0;
      out_entry    = '0;

      unique case (state_ff)
         S_LOAD: begin
            if (!in_empty) begin
               in_pop = 1'b1;
               wr_en  = 1'b1;
               if (in_entry.last) begin
                  load_idx_in  = '0;
                  ones_left_in = in_entry.mode ? in_entry.lz : '0;
                  dig_cnt_in   = '0;
                  div_idx_in   = '0;
                  rem_in       = '0;
                  nz_in        = 1'b0;
                  if (in_entry.nonzero) begin
                     state_in = S_DIV;
                  end else if (in_entry.mode && in_entry.lz != '0) begin
                     state_in = S_ONES;
                  end else begin
                     state_in = S_EMPTY;
                  end
               end else begin
                  load_idx_in = load_idx_ff + 1'b1;
               end
            end
         end
         S_DIV: begin
            // read byte k while writing back the quotient byte k-1
            div_idx_in = div_idx_ff + 1'b1;
            if (div_idx_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = wb_idx[IDX_W-1:0];
               wr_data = divres.quot;
               rem_in  = divres.rem;
               nz_in   = nz_step;
            end
            if (div_idx_ff == CNT_W'(NUM_BYTES)) begin
               // end of a pass: push the remainder as the next digit
               stk_we     = 1'b1;
               dig_cnt_in = dig_next;
               div_idx_in = '0;
               rem_in     = '0;
               nz_in      = 1'b0;
               if (!(nz_step && dig_next < DCW'(MAX_DIGITS))) begin
                  state_in = (ones_left_ff != '0) ? S_ONES : S_RD;
               end
            end
         end
         S_ONES: begin
            if (!out_full) begin
               out_push              = 1'b1;
               out_entry.symbol      = CHAR_ONE;
               out_entry.last_symbol = (ones_left_ff == LZ_W'(1)) && (dig_cnt_ff == '0);
               ones_left_in          = ones_left_ff - 1'b1;
               if (ones_left_ff == LZ_W'(1)) begin
                  state_in = (dig_cnt_ff != '0) ? S_RD : S_LOAD;
               end
            end
         end
         S_RD: begin
            stk_rd_en  = 1'b1;
            dig_cnt_in = dig_cnt_ff - 1'b1;
            state_in   = S_DIGIT;
         end
         S_DIGIT: begin
            if (!out_full) begin
               out_push              = 1'b1;
               out_entry.symbol      = alpha_char(stk_rd_ff);
               out_entry.last_symbol = (dig_cnt_ff == '0);
               state_in              = (dig_cnt_ff == '0) ? S_LOAD : S_RD;
            end
         end
         S_EMPTY: begin
            if (!out_full) begin
               out_push               = 1'b1;
               out_entry.last_symbol  = 1'b1;
               out_entry.empty_result = 1'b1;
               state_in               = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         load_idx_ff  <= '0;
         div_idx_ff   <= '0;
         rem_ff       <= '0;
         nz_ff        <= 1'b0;
         dig_cnt_ff   <= '0;
         ones_left_ff <= '0;
      end else begin
         state_ff     <= state_in;
         load_idx_ff  <= load_idx_in;
         div_idx_ff   <= div_idx_in;
         rem_ff       <= rem_in;
         nz_ff        <= nz_in;
         dig_cnt_ff   <= dig_cnt_in;
         ones_left_ff <= ones_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         work_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= work_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[dig_cnt_ff[SAW-1:0]] <= divres.rem;
      end
      if (stk_rd_en) begin
         stk_rd_ff <= stack_mem[stk_rd_idx[SAW-1:0]];
      end
   end

endmodule

`default_nettype wire

// ===== sv/b58e_checker.sv =====
// Port-level checks of the base58 encoder, bound to the top level.
// Depends on: base58_encoder_assert.svh, base58_encoder.
`default_nettype none

`include "base58_encoder_assert.svh"

module b58e_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       pop,
   input wire logic       empty,
   input wire logic [7:0] rsp_symbol,
   input wire logic       rsp_last_symbol,
   input wire logic       rsp_empty_result
);

   logic empty_shown;   // an empty-marked result waits at the ports
   logic char_shown;    // a real character waits at the ports

   assign empty_shown = !empty && rsp_empty_result;
   assign char_shown  = !empty && !rsp_empty_result;

   // An empty encoding is always a single, final result
   `B58E_ASSERT(a_empty_is_last, empty_shown |-> rsp_last_symbol, "empty result not last")

   // An empty encoding carries the fixed zero symbol
   `B58E_ASSERT(a_empty_symbol, empty_shown |-> rsp_symbol == 8'd0, "empty with symbol")

   // Real characters are never the null code
   `B58E_ASSERT(a_char_nonzero, char_shown |-> rsp_symbol != 8'd0, "null character")

   // Nothing is waiting right after reset
   `B58E_ASSERT_ALWAYS(a_reset_empty, reset |=> empty, "result shown after reset")

   // A waiting result stays until taken
   `B58E_ASSERT(a_result_held, (!empty && !pop) |=> !empty, "waiting result dropped")

endmodule

bind base58_encoder b58e_checker u_b58e_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the base58 encoder: full numbers in, characters out.
// Holds a scoreboard class that predicts each encoding; depends on b58e_pkg and
// base58_encoder.
`default_nettype none

class char_scoreboard;
   localparam int NB = b58e_pkg::NUM_BYTES_DEF;

   bit                        mode;
   logic [7:0]                number[NB];
   int                        loaded;
   int                        zero_prefix;
   bit                        leading;
   b58e_pkg::sym_entry_type   expected_chars[$];

   function new();
      mode        = 1'b1;
      loaded      = 0;
      zero_prefix = 0;
      leading     = 1'b1;
   endfunction

   function void set_mode(bit m);
      mode = m;
   endfunction

   // Divide the held number by 58 until it is zero and queue its characters.
   function void encode_number();
      string                   glyphs;
      logic [7:0]              work[NB];
      logic [5:0]              digits[$];
      b58e_pkg::sym_entry_type chars[$];
      b58e_pkg::sym_entry_type c;
      bit                      nonzero;
      int                      acc;
      int                      rem;
      glyphs  = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
      nonzero = 1'b0;
      for (int i = 0; i < NB; i++) begin
         work[i] = number[i];
         if (work[i] != 8'd0) nonzero = 1'b1;
      end
      while (nonzero) begin
         rem     = 0;
         nonzero = 1'b0;
         for (int i = 0; i < NB; i++) begin
            acc     = rem * 256 + int'(work[i]);
            work[i] = 8'(acc / 58);
            rem     = acc % 58;
            if (work[i] != 8'd0) nonzero = 1'b1;
         end
         digits = {digits, 6'(rem)};
      end
      c.last_symbol  = 1'b0;
      c.empty_result = 1'b0;
      if (mode) begin
         c.symbol = 8'h31;
         repeat (zero_prefix) chars = {chars, c};
      end
      for (int i = digits.size() - 1; i >= 0; i--) begin
         c.symbol = glyphs[int'(digits[i])];
         chars = {chars, c};
      end
      if (chars.size() == 0) begin
         c.symbol       = 8'h00;
         c.last_symbol  = 1'b1;
         c.empty_result = 1'b1;
         chars = {chars, c};
      end else begin
         chars[chars.size() - 1].last_symbol = 1'b1;
      end
      expected_chars = {expected_chars, chars};
   endfunction

   function void note_byte(logic [7:0] b);
      if (loaded < NB) number[loaded] = b;
      if (leading && b == 8'd0) zero_prefix++;
      else leading = 1'b0;
      loaded++;
      if (loaded == NB) begin
         encode_number();
         loaded      = 0;
         zero_prefix = 0;
         leading     = 1'b1;
      end
   endfunction

   // Compare one character with the oldest prediction; empty string means a match.
   function string check_symbol(b58e_pkg::sym_entry_type got);
      b58e_pkg::sym_entry_type exp_c;
      if (expected_chars.size() == 0)
         return $sformatf("unexpected char sym=%h last=%b empty=%b",
                          got.symbol, got.last_symbol, got.empty_result);
      exp_c = expected_chars.pop_front();
      if (got != exp_c)
         return $sformatf("sym=%h/%h last=%b/%b empty=%b/%b (got/expected)",
                          got.symbol, exp_c.symbol, got.last_symbol, exp_c.last_symbol,
                          got.empty_result, exp_c.empty_result);
      return "";
   endfunction
endclass

module tb_top;
   import b58e_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NB = NUM_BYTES_DEF;
   // Wait for the block to finish a number, with margin
   localparam int SETTLE_CYCLES = 1100;
   localparam bit MODE_RAW          = 1'b0;
   localparam bit MODE_LEADING_ONES = 1'b1;

   typedef enum int {FILL_RANDOM, FILL_MAX, FILL_SPARSE} fill_kind_type;

   logic       clock                 = 1'b0;
   logic       reset                 = 1'b1;
   logic       push                  = 1'b0;
   logic [7:0] req_data_byte         = 8'd0;
   logic       pop                   = 1'b0;
   logic       valid                 = 1'b0;
   logic       csr_leading_ones_mode = 1'b0;
   logic       full;
   logic       empty;
   logic [7:0] rsp_symbol;
   logic       rsp_last_symbol;
   logic       rsp_empty_result;
   logic       ready;

   int             fail_count      = 0;
   int             sender_idle_pct = 0;
   int             recv_stall_pct  = 0;
   char_scoreboard tracker         = new;

   base58_encoder DUT (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_data_byte         (req_data_byte),
      .pop                   (pop),
      .empty                 (empty),
      .rsp_symbol            (rsp_symbol),
      .rsp_last_symbol       (rsp_last_symbol),
      .rsp_empty_result      (rsp_empty_result),
      .valid                 (valid),
      .ready                 (ready),
      .csr_leading_ones_mode (csr_leading_ones_mode)
   );

   // 4 ns period: high half, then low half
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // Offer one byte, idling first at random; hold it until the transfer happens.
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push          <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (full !== 1'b0);
      tracker.note_byte(b);
   endtask

   // Send one whole number: a run of zero bytes, then fill of the given kind.
   task automatic send_number(input int zeros, input fill_kind_type fill);
      logic [7:0] b;
      for (int i = 0; i < NB; i++) begin
         if (i < zeros) b = 8'd0;
         else if (fill == FILL_MAX) b = 8'hFF;
         else if (fill == FILL_SPARSE) b = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom);
         else b = 8'($urandom);
         send_byte(b);
      end
   endtask

   task automatic stop_push();
      @(negedge clock);
      push <= 1'b0;
   endtask

   // Wait until every predicted character has come, then let the block settle.
   task automatic drain();
      while (tracker.expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit m);
      @(negedge clock);
      valid                 <= 1'b1;
      csr_leading_ones_mode <= m;
      do @(posedge clock); while (ready !== 1'b1);
      tracker.set_mode(m);
      @(negedge clock);
      valid <= 1'b0;
   endtask

   // Result side: stall pop at random, check each character on its transfer.
   always @(negedge clock) begin
      pop <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
   end

   always @(posedge clock) begin
      sym_entry_type got;
      string         msg;
      if (!reset && pop && !empty) begin
         got.symbol       = rsp_symbol;
         got.last_symbol  = rsp_last_symbol;
         got.empty_result = rsp_empty_result;
         msg = tracker.check_symbol(got);
         if (msg != "") report_mismatch(msg);
      end
   end

   initial begin
      int            zeros;
      int            pick;
      fill_kind_type fill;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero number and leading zeros in both modes, byte extremes.
      // Mode is at its reset value (leading ones) here.
      send_number(NB, FILL_RANDOM);
      send_number(3, FILL_MAX);
      send_number(0, FILL_MAX);
      stop_push();
      drain();
      write_mode(MODE_RAW);
      send_number(NB, FILL_RANDOM);
      for (int i = 0; i < NB - 1; i++) send_byte(8'd0);
      send_byte(8'd57);
      stop_push();
      drain();

      // Random: four idling phases, mode flipped between them.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin sender_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         write_mode(phase[0] ? MODE_RAW : MODE_LEADING_ONES);
         for (int n = 0; n < 3; n++) begin
            // Mostly no prefix; some short, long or complete zero runs
            pick = $urandom_range(9);
            if (pick < 5) zeros = 0;
            else if (pick < 8) zeros = $urandom_range(NB - 1, 1);
            else if (pick == 8) zeros = NB;
            else zeros = $urandom_range(NB - 1, NB - 5);
            pick = $urandom_range(5);
            fill = (pick == 5) ? FILL_MAX : (pick == 4) ? FILL_SPARSE : FILL_RANDOM;
            send_number(zeros, fill);
         end
         stop_push();
         drain();
      end

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout: %0d chars still expected", tracker.expected_chars.size());
      $display("*** FAILED ***");
      $finish;
   end
endmodule

`default_nettype wire
